// File: rtl/lpp_pkg.sv
`timescale 1ns / 1ps
package lpp_pkg;

	// Fixed grammar geometry, set by the widths of the item fields.
	localparam int unsigned TERMINALS    = 64;
	localparam int unsigned NONTERMINALS = 64;
	localparam int unsigned PRODUCTIONS  = 256;
	localparam int unsigned MAX_BODY     = 8;

	localparam int unsigned SYM_W   = 7;
	localparam int unsigned TERM_W  = 6;
	localparam int unsigned ROW_W   = 6;
	localparam int unsigned PROD_W  = 8;
	localparam int unsigned LEN_W   = 4;
	localparam int unsigned POS_W   = 3;
	localparam int unsigned EV_W    = 4;
	localparam int unsigned EXP_W   = 6;
	localparam int unsigned TBL_AW  = ROW_W + TERM_W;
	localparam int unsigned TBL_DW  = PROD_W + 1;
	localparam int unsigned SYM_AW  = PROD_W + POS_W;
	localparam int unsigned TBL_DEPTH = NONTERMINALS * TERMINALS;

	localparam logic [SYM_W-1:0] NT_BASE    = 7'd64;
	localparam logic [SYM_W-1:0] END_MARKER = 7'd0;
	localparam logic [SYM_W-1:0] START_RESET = 7'd64;

	// Input operation codes.
	localparam logic [1:0] OP_TABLE = 2'd0;
	localparam logic [1:0] OP_BODY  = 2'd1;
	localparam logic [1:0] OP_BEGIN = 2'd2;
	localparam logic [1:0] OP_TOKEN = 2'd3;

	// Result event codes.
	localparam logic [EV_W-1:0] EV_DERIV      = 4'd0;
	localparam logic [EV_W-1:0] EV_MATCHED    = 4'd1;
	localparam logic [EV_W-1:0] EV_ACCEPTED   = 4'd2;
	localparam logic [EV_W-1:0] EV_MISMATCH   = 4'd3;
	localparam logic [EV_W-1:0] EV_NO_ENTRY   = 4'd4;
	localparam logic [EV_W-1:0] EV_EMPTY      = 4'd5;
	localparam logic [EV_W-1:0] EV_OVERFLOW   = 4'd6;
	localparam logic [EV_W-1:0] EV_EXP_LIMIT  = 4'd7;
	localparam logic [EV_W-1:0] EV_NOT_ACTIVE = 4'd8;

	// Register index of the start symbol.
	localparam logic REG_START = 1'b0;

	// Write port bundle of the grammar tables.
	typedef struct packed {
		logic              tbl_we;
		logic [TBL_AW-1:0] tbl_waddr;
		logic [TBL_DW-1:0] tbl_wdata;
		logic              len_we;
		logic [PROD_W-1:0] len_waddr;
		logic [LEN_W-1:0]  len_wdata;
		logic              sym_we;
		logic [SYM_AW-1:0] sym_waddr;
		logic [SYM_W-1:0]  sym_wdata;
	} tbl_wr_t;

	// Read addresses of the grammar tables.
	typedef struct packed {
		logic [TBL_AW-1:0] tbl_raddr;
		logic [PROD_W-1:0] len_raddr;
		logic [SYM_AW-1:0] sym_raddr;
	} tbl_rd_t;

endpackage

// File: rtl/lpp_in_if.sv
`timescale 1ns / 1ps
interface lpp_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [5:0] nonterminal_row;
	logic [5:0] terminal_kind;
	logic [7:0] production_index;
	logic       entry_valid;
	logic [3:0] body_length;
	logic [2:0] body_position;
	logic [6:0] body_symbol;

	modport source (output valid, op, nonterminal_row, terminal_kind, production_index,
		entry_valid, body_length, body_position, body_symbol, input ready);
	modport sink (input valid, op, nonterminal_row, terminal_kind, production_index,
		entry_valid, body_length, body_position, body_symbol, output ready);
endinterface

// File: rtl/lpp_out_if.sv
`timescale 1ns / 1ps
interface lpp_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] event_res;
	logic [7:0] applied_production;
	logic [6:0] stack_top_symbol;
	logic       last;

	modport source (output valid, event_res, applied_production, stack_top_symbol, last,
		input ready);
	modport sink (input valid, event_res, applied_production, stack_top_symbol, last,
		output ready);
endinterface

// File: rtl/lpp_tables.sv
`timescale 1ns / 1ps
module lpp_tables (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lpp_pkg::tbl_wr_t                  wr,
	input  lpp_pkg::tbl_rd_t                  rd,
	output logic [lpp_pkg::TBL_DW-1:0]        tbl_rdata,
	output logic [lpp_pkg::LEN_W-1:0]         len_rdata,
	output logic [lpp_pkg::SYM_W-1:0]         sym_rdata,
	output logic                              clear_busy
);

	logic [lpp_pkg::TBL_DW-1:0] tbl_mem [lpp_pkg::TBL_DEPTH];
	logic [lpp_pkg::LEN_W-1:0]  len_mem [lpp_pkg::PRODUCTIONS];
	logic [lpp_pkg::SYM_W-1:0]  sym_mem [lpp_pkg::PRODUCTIONS * lpp_pkg::MAX_BODY];
	logic [lpp_pkg::TBL_AW:0]   clr_q;

	assign clear_busy = !clr_q[lpp_pkg::TBL_AW];

	// Sweep counter that marks every parse table entry empty after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clear_busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Parse table: the clearing sweep owns the write port until it ends.
	always_ff @(posedge clk) begin
		if (clear_busy) begin
			tbl_mem[clr_q[lpp_pkg::TBL_AW-1:0]] <= '0;
		end else if (wr.tbl_we) begin
			tbl_mem[wr.tbl_waddr] <= wr.tbl_wdata;
		end
		tbl_rdata <= tbl_mem[rd.tbl_raddr];
	end

	// Production lengths.
	always_ff @(posedge clk) begin
		if (wr.len_we) begin
			len_mem[wr.len_waddr] <= wr.len_wdata;
		end
		len_rdata <= len_mem[rd.len_raddr];
	end

	// Production body symbols.
	always_ff @(posedge clk) begin
		if (wr.sym_we) begin
			sym_mem[wr.sym_waddr] <= wr.sym_wdata;
		end
		sym_rdata <= sym_mem[rd.sym_raddr];
	end

endmodule

// File: rtl/lpp_stack.sv
`timescale 1ns / 1ps
module lpp_stack #(
	parameter int unsigned DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [lpp_pkg::SYM_W-1:0]  wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [lpp_pkg::SYM_W-1:0]  rdata
);

	logic [lpp_pkg::SYM_W-1:0] mem [DEPTH];

	// Symbol stack with one write and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/ll1_table_driven_parser.sv
`timescale 1ns / 1ps
// LL(1) predictive parser driven by a parse table and production bodies held in on-chip
// memory. After reset the parse table is swept clear, entry by entry, during which no
// transaction is taken on the input channel (register writes are). A begin writes the end
// marker as it is taken and the start symbol from its own state. A token is handled by
// reading the stack top and deciding it; each expansion adds a table lookup, a length lookup
// and a closing pass of the push loop, and each body symbol pushed takes a read step and a
// write step, since every symbol passes through the single stack write port and the single
// body memory read port. The input is not ready while a token is being worked on, and each
// result waits in an output register until it is taken, which stalls the sequencer.
module ll1_table_driven_parser #(
	parameter int unsigned STACK_DEPTH    = 256,
	parameter int unsigned MAX_EXPANSIONS = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	lpp_in_if.sink      in_ch,
	lpp_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW   = $clog2(STACK_DEPTH);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_BEGIN   = 4'd1;
	localparam logic [3:0] S_TOP_RD  = 4'd2;
	localparam logic [3:0] S_TOP_DEC = 4'd3;
	localparam logic [3:0] S_TBL_DEC = 4'd4;
	localparam logic [3:0] S_LEN_DEC = 4'd5;
	localparam logic [3:0] S_PUSH_RD = 4'd6;
	localparam logic [3:0] S_PUSH_WR = 4'd7;

	logic [3:0]                  state_q;
	logic [lpp_pkg::SYM_W-1:0]   start_q;
	logic [SP_W-1:0]             sp_q;
	logic                        active_q;
	logic [lpp_pkg::TERM_W-1:0]  tok_q;
	logic [lpp_pkg::SYM_W-1:0]   top_q;
	logic [lpp_pkg::PROD_W-1:0]  prod_q;
	logic [lpp_pkg::EXP_W-1:0]   exp_q;
	logic [lpp_pkg::LEN_W-1:0]   cnt_q;
	logic                        ovalid_q;
	logic [lpp_pkg::EV_W-1:0]    oev_q;
	logic [lpp_pkg::PROD_W-1:0]  oprod_q;
	logic [lpp_pkg::SYM_W-1:0]   otop_q;
	logic                        olast_q;

	lpp_pkg::tbl_wr_t            wr;
	lpp_pkg::tbl_rd_t            rd;
	logic [lpp_pkg::TBL_DW-1:0]  tbl_rdata;
	logic [lpp_pkg::LEN_W-1:0]   len_rdata;
	logic [lpp_pkg::SYM_W-1:0]   sym_rdata;
	logic                        clear_busy;
	logic                        stk_we;
	logic [AW-1:0]               stk_waddr;
	logic [lpp_pkg::SYM_W-1:0]   stk_wdata;
	logic [AW-1:0]               stk_raddr;
	logic [lpp_pkg::SYM_W-1:0]   stk_rdata;

	logic                        in_fire;
	logic                        out_free;
	logic                        res_load;
	logic [lpp_pkg::SYM_W-1:0]   nt_code;
	logic [lpp_pkg::LEN_W-1:0]   len_sat;
	logic [SP_W:0]               grown_sp;
	logic [lpp_pkg::LEN_W-1:0]   cnt_dec;
	logic                        cfg_wr;

	assign in_ch.ready = (state_q == S_IDLE) && !clear_busy;
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_free    = !ovalid_q || out_ch.ready;

	assign out_ch.valid              = ovalid_q;
	assign out_ch.event_res          = oev_q;
	assign out_ch.applied_production = oprod_q;
	assign out_ch.stack_top_symbol   = otop_q;
	assign out_ch.last               = olast_q;

	// Register port: one register, written in the access phase.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == lpp_pkg::REG_START);
	assign prdata = (paddr[2] == lpp_pkg::REG_START) ? {25'd0, start_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= lpp_pkg::START_RESET;
		end else if (cfg_wr) begin
			start_q <= pwdata[lpp_pkg::SYM_W-1:0];
		end
	end

	// Load items write the grammar tables directly.
	always_comb begin
		len_sat = (in_ch.body_length > lpp_pkg::LEN_W'(lpp_pkg::MAX_BODY)) ?
			lpp_pkg::LEN_W'(lpp_pkg::MAX_BODY) : in_ch.body_length;
		wr.tbl_we    = in_fire && (in_ch.op == lpp_pkg::OP_TABLE);
		wr.tbl_waddr = {in_ch.nonterminal_row, in_ch.terminal_kind};
		wr.tbl_wdata = {in_ch.entry_valid, in_ch.production_index};
		wr.len_we    = in_fire && (in_ch.op == lpp_pkg::OP_BODY);
		wr.len_waddr = in_ch.production_index;
		wr.len_wdata = len_sat;
		wr.sym_we    = wr.len_we;
		wr.sym_waddr = {in_ch.production_index, in_ch.body_position};
		wr.sym_wdata = in_ch.body_symbol;
	end

	// Lookup addresses follow the data just read so that a stalled step rereads the same word.
	assign nt_code = ((state_q == S_TOP_DEC) ? stk_rdata : top_q) - lpp_pkg::NT_BASE;
	assign cnt_dec = cnt_q - 1'b1;
	always_comb begin
		rd.tbl_raddr = {nt_code[lpp_pkg::ROW_W-1:0], tok_q};
		rd.len_raddr = (state_q == S_TBL_DEC) ? tbl_rdata[lpp_pkg::PROD_W-1:0] : prod_q;
		rd.sym_raddr = {prod_q, cnt_dec[lpp_pkg::POS_W-1:0]};
	end

	// Stack port: the begin item lays down the end marker and start symbol, pushes follow.
	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = sp_q[AW-1:0];
		stk_wdata = sym_rdata;
		if (in_fire && (in_ch.op == lpp_pkg::OP_BEGIN)) begin
			stk_we    = 1'b1;
			stk_waddr = '0;
			stk_wdata = lpp_pkg::END_MARKER;
		end else if (state_q == S_BEGIN) begin
			stk_we    = 1'b1;
			stk_waddr = AW'(1);
			stk_wdata = start_q;
		end else if (state_q == S_PUSH_WR) begin
			stk_we    = 1'b1;
		end
	end
	assign stk_raddr = AW'(sp_q - 1'b1);

	// Depth the stack would reach once the body replaces the nonterminal.
	assign grown_sp = {1'b0, sp_q} - 1'b1 + (SP_W + 1)'(
		(len_rdata > lpp_pkg::LEN_W'(lpp_pkg::MAX_BODY)) ?
		lpp_pkg::LEN_W'(lpp_pkg::MAX_BODY) : len_rdata);

	lpp_tables u_tables (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.rd         (rd),
		.tbl_rdata  (tbl_rdata),
		.len_rdata  (len_rdata),
		.sym_rdata  (sym_rdata),
		.clear_busy (clear_busy)
	);

	lpp_stack #(
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// A result is loaded when the sequencer decides an event and the output register is free.
	always_comb begin
		res_load = 1'b0;
		unique case (state_q)
			S_TOP_RD:  res_load = !active_q || sp_q == '0;
			S_TOP_DEC: res_load = stk_rdata < lpp_pkg::NT_BASE;
			S_TBL_DEC: res_load = !(tbl_rdata[lpp_pkg::PROD_W] &&
				exp_q < lpp_pkg::EXP_W'(MAX_EXPANSIONS));
			S_LEN_DEC: res_load = 1'b1;
			default:   res_load = 1'b0;
		endcase
		res_load = res_load && out_free;
	end

	// Output valid: set by a new result, cleared once the waiting one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (res_load) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// Sequencer: one stack step per pass, each result loaded into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sp_q     <= '0;
			active_q <= 1'b0;
			exp_q    <= '0;
			cnt_q    <= '0;
			tok_q    <= '0;
			top_q    <= '0;
			prod_q   <= '0;
			oev_q    <= '0;
			oprod_q  <= '0;
			otop_q   <= '0;
			olast_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (in_ch.op == lpp_pkg::OP_BEGIN) begin
							state_q <= S_BEGIN;
						end else if (in_ch.op == lpp_pkg::OP_TOKEN) begin
							tok_q   <= in_ch.terminal_kind;
							exp_q   <= '0;
							state_q <= S_TOP_RD;
						end
					end
				end
				S_BEGIN: begin
					sp_q     <= SP_W'(2);
					active_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_TOP_RD: begin
					if (!active_q || sp_q == '0) begin
						if (out_free) begin
							oev_q    <= active_q ? lpp_pkg::EV_EMPTY : lpp_pkg::EV_NOT_ACTIVE;
							oprod_q  <= '0;
							otop_q   <= '0;
							olast_q  <= 1'b1;
							active_q <= 1'b0;
							state_q  <= S_IDLE;
						end
					end else begin
						state_q <= S_TOP_DEC;
					end
				end
				S_TOP_DEC: begin
					if (stk_rdata >= lpp_pkg::NT_BASE) begin
						top_q   <= stk_rdata;
						state_q <= S_TBL_DEC;
					end else if (out_free) begin
						oprod_q  <= '0;
						otop_q   <= stk_rdata;
						olast_q  <= 1'b1;
						state_q  <= S_IDLE;
						if (stk_rdata == lpp_pkg::END_MARKER && tok_q == '0) begin
							oev_q    <= lpp_pkg::EV_ACCEPTED;
							active_q <= 1'b0;
						end else if (stk_rdata == {1'b0, tok_q}) begin
							oev_q <= lpp_pkg::EV_MATCHED;
							sp_q  <= sp_q - 1'b1;
						end else begin
							oev_q    <= lpp_pkg::EV_MISMATCH;
							active_q <= 1'b0;
						end
					end
				end
				S_TBL_DEC: begin
					if (tbl_rdata[lpp_pkg::PROD_W] &&
						exp_q < lpp_pkg::EXP_W'(MAX_EXPANSIONS)) begin
						prod_q  <= tbl_rdata[lpp_pkg::PROD_W-1:0];
						state_q <= S_LEN_DEC;
					end else if (out_free) begin
						oev_q    <= tbl_rdata[lpp_pkg::PROD_W] ?
							lpp_pkg::EV_EXP_LIMIT : lpp_pkg::EV_NO_ENTRY;
						oprod_q  <= '0;
						otop_q   <= top_q;
						olast_q  <= 1'b1;
						active_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				S_LEN_DEC: begin
					if (out_free) begin
						otop_q   <= top_q;
						if (grown_sp > (SP_W + 1)'(STACK_DEPTH)) begin
							oev_q    <= lpp_pkg::EV_OVERFLOW;
							oprod_q  <= '0;
							olast_q  <= 1'b1;
							active_q <= 1'b0;
							state_q  <= S_IDLE;
						end else begin
							oev_q   <= lpp_pkg::EV_DERIV;
							oprod_q <= prod_q;
							olast_q <= 1'b0;
							sp_q    <= sp_q - 1'b1;
							exp_q   <= exp_q + 1'b1;
							cnt_q   <= (len_rdata > lpp_pkg::LEN_W'(lpp_pkg::MAX_BODY)) ?
								lpp_pkg::LEN_W'(lpp_pkg::MAX_BODY) : len_rdata;
							state_q <= S_PUSH_RD;
						end
					end
				end
				S_PUSH_RD: begin
					state_q <= (cnt_q == '0) ? S_TOP_RD : S_PUSH_WR;
				end
				S_PUSH_WR: begin
					sp_q    <= sp_q + 1'b1;
					cnt_q   <= cnt_dec;
					state_q <= S_PUSH_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/lpp_checker.sv
`timescale 1ns / 1ps
module lpp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] in_op,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] out_event,
	input logic       out_last,
	input logic       pready
);

	// A waiting result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_event) && $stable(out_last))
		else $error("result changed while stalled");

	// A token transaction keeps the input closed on the following cycle.
	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_op == lpp_pkg::OP_TOKEN |=> !in_ready)
		else $error("input reopened right after a token");

	// Only derivations are followed by further results of the same token.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == (out_event != lpp_pkg::EV_DERIV)))
		else $error("last flag disagrees with the event");

	// The register port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind ll1_table_driven_parser lpp_checker u_lpp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_op     (in_ch.op),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_event (out_ch.event_res),
	.out_last  (out_ch.last),
	.pready    (pready)
);

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;

	localparam int unsigned STACK_LIMIT = 256;
	localparam int unsigned EXP_LIMIT   = 63;

	typedef struct packed {
		logic [1:0] op;
		logic [5:0] row;
		logic [5:0] kind;
		logic [7:0] prod;
		logic       ent_ok;
		logic [3:0] blen;
		logic [2:0] bpos;
		logic [6:0] bsym;
	} parser_item_t;

	typedef struct packed {
		logic [lpp_pkg::EV_W-1:0] ev;
		logic [7:0]               prod;
		logic [6:0]               top;
		logic                     last;
	} parse_event_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	lpp_in_if  in_ch();
	lpp_out_if out_ch();

	ll1_table_driven_parser dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow of the parser state, updated as each transaction is accepted.
	logic [8:0] sh_table [lpp_pkg::TBL_DEPTH];
	int         sh_len [lpp_pkg::PRODUCTIONS];
	logic [6:0] sh_sym [lpp_pkg::PRODUCTIONS*lpp_pkg::MAX_BODY];
	logic [6:0] sh_stack [STACK_LIMIT];
	int         sh_sp;
	bit         sh_active;
	logic [6:0] sh_start;

	parse_event_t  events_due[$];
	parser_item_t  items_todo[$];
	int unsigned   n_pushed, n_taken, n_fail;
	int unsigned   send_idle_pct, recv_stall_pct;
	bit            hold_send;
	logic [6:0]    body_buf [lpp_pkg::MAX_BODY];

	// Clock.
	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	// Appends one expected result transaction.
	function automatic void queue_result(input logic [lpp_pkg::EV_W-1:0] ev,
			input logic [7:0] prod, input logic [6:0] top, input logic last);
		parse_event_t e;
		e = {ev, prod, top, last};
		events_due = {events_due, e};
	endfunction

	// Works out the events that one accepted transaction causes.
	task automatic parse_item(input parser_item_t it);
		logic [6:0] top;
		logic [8:0] ent;
		int         nexp, len;
		bit         done;
		nexp = 0;
		done = 0;
		case (it.op)
			lpp_pkg::OP_TABLE: sh_table[{it.row, it.kind}] = {it.ent_ok, it.prod};
			lpp_pkg::OP_BODY: begin
				sh_len[it.prod] = (int'(it.blen) > int'(lpp_pkg::MAX_BODY)) ?
					int'(lpp_pkg::MAX_BODY) : int'(it.blen);
				sh_sym[{it.prod, it.bpos}] = it.bsym;
			end
			lpp_pkg::OP_BEGIN: begin
				sh_stack[0] = lpp_pkg::END_MARKER;
				sh_stack[1] = sh_start;
				sh_sp = 2;
				sh_active = 1;
			end
			default: begin
				if (!sh_active) begin
					queue_result(lpp_pkg::EV_NOT_ACTIVE, 8'd0, 7'd0, 1'b1);
					done = 1;
				end
				while (!done) begin
					done = 1;
					if (sh_sp == 0 || sh_sp > STACK_LIMIT) begin
						sh_active = 0;
						queue_result(lpp_pkg::EV_EMPTY, 8'd0, 7'd0, 1'b1);
					end else begin
						top = sh_stack[sh_sp-1];
						if (top == lpp_pkg::END_MARKER && it.kind == 0) begin
							sh_active = 0;
							queue_result(lpp_pkg::EV_ACCEPTED, 8'd0, top, 1'b1);
						end else if (top < lpp_pkg::NT_BASE) begin
							if (top[5:0] == it.kind) begin
								sh_sp--;
								queue_result(lpp_pkg::EV_MATCHED, 8'd0, top, 1'b1);
							end else begin
								sh_active = 0;
								queue_result(lpp_pkg::EV_MISMATCH, 8'd0, top, 1'b1);
							end
						end else begin
							ent = sh_table[{top[5:0], it.kind}];
							if (!ent[8]) begin
								sh_active = 0;
								queue_result(lpp_pkg::EV_NO_ENTRY, 8'd0, top, 1'b1);
							end else if (nexp >= EXP_LIMIT) begin
								sh_active = 0;
								queue_result(lpp_pkg::EV_EXP_LIMIT, 8'd0, top, 1'b1);
							end else begin
								len = sh_len[ent[7:0]];
								if (sh_sp - 1 + len > STACK_LIMIT) begin
									sh_active = 0;
									queue_result(lpp_pkg::EV_OVERFLOW, 8'd0, top, 1'b1);
								end else begin
									// Derivation: pop the nonterminal, push the body reversed.
									queue_result(lpp_pkg::EV_DERIV, ent[7:0], top, 1'b0);
									nexp++;
									sh_sp--;
									for (int i = len; i > 0; i--) begin
										sh_stack[sh_sp] = sh_sym[{ent[7:0], 3'(i-1)}];
										sh_sp++;
									end
									done = 0;
								end
							end
						end
					end
				end
			end
		endcase
	endtask

	// Driver: presents queued items, holding each until it is taken.
	always @(posedge clk) begin
		if (in_ch.valid && !in_ch.ready) begin
			in_ch.valid <= 1'b1;
		end else if (items_todo.size() > 0 && !hold_send && arst_n &&
				$urandom_range(99) >= send_idle_pct) begin
			parser_item_t it;
			it = items_todo.pop_front();
			in_ch.valid            <= 1'b1;
			in_ch.op               <= it.op;
			in_ch.nonterminal_row  <= it.row;
			in_ch.terminal_kind    <= it.kind;
			in_ch.production_index <= it.prod;
			in_ch.entry_valid      <= it.ent_ok;
			in_ch.body_length      <= it.blen;
			in_ch.body_position    <= it.bpos;
			in_ch.body_symbol      <= it.bsym;
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// Receiver back-pressure.
	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: checks each result transaction, then predicts from each input one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				parse_event_t want;
				if (events_due.size() == 0) begin
					$error("unexpected result: event %0d", out_ch.event_res);
					n_fail++;
				end else begin
					want = events_due.pop_front();
					if (out_ch.event_res !== want.ev) begin
						$error("event_res: expected %0d, got %0d", want.ev, out_ch.event_res);
						n_fail++;
					end
					if (out_ch.applied_production !== want.prod) begin
						$error("applied_production: expected %0d, got %0d", want.prod,
							out_ch.applied_production);
						n_fail++;
					end
					if (out_ch.stack_top_symbol !== want.top) begin
						$error("stack_top_symbol: expected %0d, got %0d", want.top,
							out_ch.stack_top_symbol);
						n_fail++;
					end
					if (out_ch.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, out_ch.last);
						n_fail++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				parse_item({in_ch.op, in_ch.nonterminal_row, in_ch.terminal_kind,
					in_ch.production_index, in_ch.entry_valid, in_ch.body_length,
					in_ch.body_position, in_ch.body_symbol});
				n_taken++;
			end
		end
	end

	// Queues one item; unused fields carry random values.
	task automatic push_item(input logic [1:0] op, input logic [5:0] row,
			input logic [5:0] kind, input logic [7:0] prod, input logic ent_ok,
			input logic [3:0] blen, input logic [2:0] bpos, input logic [6:0] bsym);
		parser_item_t it;
		it = {op, row, kind, prod, ent_ok, blen, bpos, bsym};
		items_todo = {items_todo, it};
		n_pushed++;
		if (n_pushed > 245) begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end else if (n_pushed > 120) begin
			send_idle_pct = 77;
			recv_stall_pct = 10;
		end
	endtask

	task automatic table_write(input int row, input int kind, input bit ok, input int prod);
		push_item(lpp_pkg::OP_TABLE, 6'(row), 6'(kind), 8'(prod), ok, 4'($urandom),
			3'($urandom), 7'($urandom));
	endtask

	// Writes a whole body from body_buf, so no position below the length is left unset.
	task automatic body_write(input int prod, input int blen);
		int n;
		n = (blen > int'(lpp_pkg::MAX_BODY)) ? int'(lpp_pkg::MAX_BODY) : blen;
		if (n == 0)
			push_item(lpp_pkg::OP_BODY, 6'($urandom), 6'($urandom), 8'(prod), 1'($urandom),
				4'(blen), 3'($urandom), 7'($urandom));
		for (int i = 0; i < n; i++)
			push_item(lpp_pkg::OP_BODY, 6'($urandom), 6'($urandom), 8'(prod), 1'($urandom),
				4'(blen), 3'(i), body_buf[i]);
	endtask

	task automatic wait_taken();
		while (n_taken != n_pushed)
			@(posedge clk);
	endtask

	task automatic token(input int kind);
		wait_taken();
		push_item(lpp_pkg::OP_TOKEN, 6'($urandom), 6'(kind), 8'($urandom), 1'($urandom),
			4'($urandom), 3'($urandom), 7'($urandom));
	endtask

	task automatic begin_parse();
		push_item(lpp_pkg::OP_BEGIN, 6'($urandom), 6'($urandom), 8'($urandom), 1'($urandom),
			4'($urandom), 3'($urandom), 7'($urandom));
	endtask

	task automatic wait_idle();
		wait_taken();
		while (events_due.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Register write: setup cycle then access cycle.
	task automatic write_start(input logic [6:0] sym);
		wait_idle();
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= 3'(4 * lpp_pkg::REG_START);
		pwdata  <= {25'd0, sym};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		sh_start = sym;
	endtask

	// Picks a token that carries the parse forward from the current stack top.
	function automatic int next_token();
		logic [6:0] top;
		int         cand[$];
		if (!sh_active || sh_sp == 0)
			return $urandom_range(63);
		top = sh_stack[sh_sp-1];
		if (top < lpp_pkg::NT_BASE)
			return int'(top);
		for (int k = 0; k < lpp_pkg::TERMINALS; k++)
			if (sh_table[{top[5:0], 6'(k)}][8])
				cand = {cand, k};
		if (cand.size() == 0)
			return $urandom_range(63);
		return cand[$urandom_range(cand.size()-1)];
	endfunction

	// Stimulus.
	initial begin
		int nts[3];
		int terms[4];
		int prods[5];
		int r, blen, ntok;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_ch.valid = 1'b0; in_ch.op = lpp_pkg::OP_TABLE; in_ch.nonterminal_row = '0;
		in_ch.terminal_kind = '0; in_ch.production_index = '0; in_ch.entry_valid = 1'b0;
		in_ch.body_length = '0; in_ch.body_position = '0; in_ch.body_symbol = '0;
		out_ch.ready = 1'b0;
		send_idle_pct = 10;
		recv_stall_pct = 77;
		hold_send = 0;
		for (int i = 0; i < lpp_pkg::TBL_DEPTH; i++)
			sh_table[i] = '0;
		for (int i = 0; i < lpp_pkg::PRODUCTIONS; i++)
			sh_len[i] = 0;
		sh_sp = 0;
		sh_active = 0;
		sh_start = lpp_pkg::START_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Token with no parse running, then a right-recursive grammar on the top row.
		token(5);
		write_start(7'd127);
		body_buf[0] = 7'd63; body_buf[1] = 7'd127;
		body_write(255, 2);
		body_write(0, 0);
		body_buf[0] = 7'd2;
		body_write(254, 1);
		table_write(63, 63, 1, 255);
		table_write(63, 0, 1, 0);
		table_write(63, 1, 1, 254);
		begin_parse();
		token(63); token(63); token(0);
		token(63);
		begin_parse();
		token(5);
		table_write(63, 5, 0, 200);
		begin_parse();
		token(5);
		begin_parse();
		token(1);

		// Self-recursion on the bottom row: expansion limit, then stack overflow.
		write_start(7'd64);
		body_buf[0] = 7'd64;
		body_write(1, 1);
		body_buf[0] = 7'd64;
		for (int i = 1; i < lpp_pkg::MAX_BODY; i++)
			body_buf[i] = 7'd1;
		body_write(2, 15);
		table_write(0, 0, 1, 1);
		table_write(0, 1, 1, 2);
		begin_parse();
		token(0);
		begin_parse();
		token(1);

		// Random grammars, each followed by a parse driven mostly by well-formed tokens.
		while (n_pushed < 370) begin
			if ($urandom_range(3) == 0) begin
				r = $urandom_range(3);
				write_start(r == 0 ? 7'd64 : r == 1 ? 7'd127 : 7'($urandom_range(64, 127)));
			end
			if (n_pushed > 300 && !hold_send && events_due.size() > 0) begin
				// Let every outstanding result drain before sending more.
				hold_send = 1;
				while (events_due.size() > 0)
					@(posedge clk);
				hold_send = 0;
			end
			nts[0] = int'(sh_start);
			nts[1] = $urandom_range(64, 127);
			nts[2] = $urandom_range(64, 127);
			foreach (terms[i])
				terms[i] = $urandom_range(1, 63);
			foreach (prods[i]) begin
				prods[i] = $urandom_range(255);
				r = $urandom_range(19);
				blen = (r < 16) ? r % 4 : $urandom_range(4, 15);
				for (int k = 0; k < lpp_pkg::MAX_BODY; k++) begin
					r = $urandom_range(99);
					body_buf[k] = (r < 60) ? 7'(terms[$urandom_range(3)]) :
						(r < 65) ? lpp_pkg::END_MARKER : 7'(nts[$urandom_range(2)]);
				end
				body_write(prods[i], blen);
			end
			foreach (nts[i])
				for (int j = 0; j < 3; j++) begin
					r = $urandom_range(9);
					table_write(nts[i] - 64,
						(r < 7) ? terms[$urandom_range(3)] : (r < 9) ? 0 : $urandom_range(63),
						1, prods[$urandom_range(4)]);
				end
			if ($urandom_range(1))
				table_write($urandom_range(63), $urandom_range(63), 0, $urandom_range(255));
			else
				table_write($urandom_range(63), $urandom_range(63), 1, prods[$urandom_range(4)]);
			begin_parse();
			ntok = $urandom_range(6, 14);
			for (int t = 0; t < ntok; t++) begin
				wait_taken();
				if (!sh_active && $urandom_range(9) < 8)
					begin_parse();
				wait_taken();
				token(($urandom_range(99) < 85) ? next_token() : $urandom_range(63));
			end
		end

		wait_idle();
		repeat (100) @(posedge clk);
		if (n_fail == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// Guard against a hang.
	initial begin
		#20_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule
